>>> rtl/wsh_pkg.sv
package wsh_pkg;

  // fixed field widths and formats
  localparam int SAMPLE_BITS     = 24;
  localparam int PHASE_FRAC_BITS = 16;
  localparam int MAX_UPSAMPLE    = 16;
  localparam int BASIS_BITS      = 24;
  localparam int SLOPE_FRAC      = 8;
  localparam int ACC_BITS        = BASIS_BITS + SLOPE_FRAC;

  // configuration
  localparam int STEP_W    = 23;
  localparam int FLOOR_W   = 24;
  localparam int COUNT_W   = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_FLOOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd2;

  localparam logic [STEP_W-1:0]  RST_PHASE_STEP   = 23'd65536;
  localparam logic [FLOOR_W-1:0] RST_SLOPE_FLOOR  = 24'd1;
  localparam logic [COUNT_W-1:0] RST_OUTPUT_COUNT = 24'd1024;

  // phase
  localparam int PHASE_W = 24;
  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1 << PHASE_FRAC_BITS);
  localparam logic [STEP_W-1:0] STEP_LEAST =
    STEP_W'(((1 << PHASE_FRAC_BITS) + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE);

  localparam logic [COUNT_W-1:0] SEEN_MAX = {COUNT_W{1'b1}};

  // datapath widths
  localparam int DIFF_W  = SAMPLE_BITS + 1;
  localparam int MAG_W   = SAMPLE_BITS + SLOPE_FRAC;
  localparam int DEN_W   = MAG_W + 1;
  localparam int QUO_W   = 36;
  localparam int DROP    = QUO_W - SLOPE_FRAC - 1;
  localparam int SLOPE_W = 35;
  localparam int MUL_W   = 35;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int NUM_W   = 60;
  localparam int BASIS_W = BASIS_BITS + 2;
  localparam int ACC_W   = 62;
  localparam int RQ_W    = ACC_W - ACC_BITS;

  localparam int SAMP_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int SAMP_MIN = -SAMP_MAX - 1;

  // sequencer counts
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] SLOPE_LAST = CNT_W'(2);
  localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(QUO_W - 1);
  localparam logic [CNT_W-1:0] HERM_LAST  = CNT_W'(8);

  // hermite steps
  localparam logic [CNT_W-1:0] HS_UU  = CNT_W'(0);
  localparam logic [CNT_W-1:0] HS_VV  = CNT_W'(1);
  localparam logic [CNT_W-1:0] HS_H01 = CNT_W'(2);
  localparam logic [CNT_W-1:0] HS_H10 = CNT_W'(3);
  localparam logic [CNT_W-1:0] HS_H11 = CNT_W'(4);
  localparam logic [CNT_W-1:0] HS_DY  = CNT_W'(5);
  localparam logic [CNT_W-1:0] HS_S0  = CNT_W'(6);
  localparam logic [CNT_W-1:0] HS_S1  = CNT_W'(7);

  // command queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [STEP_W-1:0]  phase_step;
    logic [FLOOR_W-1:0] slope_floor;
    logic [COUNT_W-1:0] output_count;
  } cfg_t;

  typedef struct packed {
    logic                   is_tail;
    logic [SAMPLE_BITS-1:0] yd;
    logic [SAMPLE_BITS-1:0] y0;
    logic [SAMPLE_BITS-1:0] y1;
    logic [SAMPLE_BITS-1:0] yu;
    logic                   has_d;
    logic                   has_u;
    logic                   last;
    logic                   fin;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic {
    F_IDLE,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SLOPE,
    B_DIV,
    B_LOOP,
    B_HERM,
    B_EMIT,
    B_TAIL,
    B_FLUSH
  } back_state_t;

endpackage

>>> rtl/wsh_cmd_fifo.sv
module wsh_cmd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wsh_pkg::cmd_t     cmd_in,
  input  logic              pop,
  output wsh_pkg::cmd_t     cmd_out,
  output wsh_pkg::q_stat_t  stat
);

  wsh_pkg::cmd_t mem [wsh_pkg::Q_DEPTH];
  logic [wsh_pkg::Q_AW-1:0] wr_ptr;
  logic [wsh_pkg::Q_AW-1:0] rd_ptr;
  logic [wsh_pkg::Q_AW:0]   count;

  assign stat.full  = (count == (wsh_pkg::Q_AW+1)'(wsh_pkg::Q_DEPTH));
  assign stat.empty = (count == '0);
  assign cmd_out    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/wsh_front.sv
module wsh_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [wsh_pkg::SAMPLE_BITS-1:0]   in_sample,
  input  logic                              in_final,
  input  wsh_pkg::q_stat_t                  q_stat,
  output logic                              q_push,
  output wsh_pkg::cmd_t                     q_cmd
);

  wsh_pkg::front_state_t state, state_next;

  logic [wsh_pkg::SAMPLE_BITS-1:0] win0, win1, win2;
  logic [wsh_pkg::COUNT_W-1:0]     seen;
  logic [wsh_pkg::COUNT_W-1:0]     seen_inc;

  // copy of the word being split into commands
  logic [wsh_pkg::SAMPLE_BITS-1:0] c_w0, c_w1, c_w2, c_s;
  logic                            c_fin, c_m3, c_m4;
  logic [2:0]                      need;
  logic [2:0]                      need_left;
  logic                            accept;

  assign accept   = in_valid && in_ready;
  assign seen_inc = (seen < wsh_pkg::SEEN_MAX) ? seen + 1'b1 : seen;

  always_comb begin
    state_next = state;
    unique case (state)
      wsh_pkg::F_IDLE: begin
        if (accept) begin
          state_next = wsh_pkg::F_PUSH;
        end
      end
      wsh_pkg::F_PUSH: begin
        if (need_left == 3'b000) begin
          state_next = wsh_pkg::F_IDLE;
        end
      end
      default: state_next = wsh_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == wsh_pkg::F_IDLE);
    q_push    = (state == wsh_pkg::F_PUSH) && (need != 3'b000) && !q_stat.full;
    need_left = q_push ? (need & (need - 3'b001)) : need;
    q_cmd     = '0;
    if (need[0]) begin
      // interval ending at the newest stored sample
      q_cmd.yd    = c_w0;
      q_cmd.y0    = c_w1;
      q_cmd.y1    = c_w2;
      q_cmd.yu    = c_s;
      q_cmd.has_d = c_m4;
      q_cmd.has_u = 1'b1;
      q_cmd.last  = !c_fin;
      q_cmd.fin   = c_fin;
    end else if (need[1]) begin
      // last interval of the record
      q_cmd.yd    = c_w1;
      q_cmd.y0    = c_w2;
      q_cmd.y1    = c_s;
      q_cmd.has_d = c_m3;
      q_cmd.fin   = 1'b1;
    end else begin
      q_cmd.is_tail = 1'b1;
      q_cmd.y1      = c_s;
      q_cmd.last    = 1'b1;
      q_cmd.fin     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c_w0  <= win0;
      c_w1  <= win1;
      c_w2  <= win2;
      c_s   <= in_sample;
      c_fin <= in_final;
      c_m3  <= (seen_inc >= wsh_pkg::COUNT_W'(3));
      c_m4  <= (seen_inc >= wsh_pkg::COUNT_W'(4));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wsh_pkg::F_IDLE;
      need  <= '0;
      seen  <= '0;
      win0  <= '0;
      win1  <= '0;
      win2  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (in_final) begin
          need <= {1'b1, (seen_inc >= wsh_pkg::COUNT_W'(2)),
                   (seen_inc >= wsh_pkg::COUNT_W'(3))};
          seen <= '0;
          win0 <= '0;
          win1 <= '0;
          win2 <= '0;
        end else begin
          need <= {2'b00, (seen_inc >= wsh_pkg::COUNT_W'(3))};
          seen <= seen_inc;
          win0 <= win1;
          win1 <= win2;
          win2 <= in_sample;
        end
      end else begin
        need <= need_left;
      end
    end
  end

endmodule

>>> rtl/wsh_back.sv
module wsh_back (
  input  logic                             clk,
  input  logic                             rst,
  input  wsh_pkg::cfg_t                    cfg,
  input  wsh_pkg::q_stat_t                 q_stat,
  input  wsh_pkg::cmd_t                    q_cmd,
  output logic                             q_pop,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [wsh_pkg::SAMPLE_BITS-1:0]  out_sample,
  output logic                             out_clip,
  output logic                             out_end
);

  wsh_pkg::back_state_t state, state_next;

  logic [wsh_pkg::CNT_W-1:0]         cnt;
  logic [wsh_pkg::CNT_W-1:0]         cidx;
  logic                              pass;
  wsh_pkg::cmd_t                     cmd;
  logic signed [wsh_pkg::DIFF_W-1:0] dd, dc, du;
  logic signed [wsh_pkg::SLOPE_W-1:0] s0, s1;
  logic signed [wsh_pkg::PROD_W-1:0] prod;
  logic signed [wsh_pkg::NUM_W-1:0]  part;
  logic [wsh_pkg::DEN_W-1:0]         rem, den;
  logic [wsh_pkg::QUO_W-1:0]         dvd;
  logic                              neg;
  logic [wsh_pkg::BASIS_W-1:0]       uu, vv, h01, h10, h11;
  logic signed [wsh_pkg::ACC_W-1:0]  acc;
  logic [wsh_pkg::PHASE_W-1:0]       phase;
  logic [wsh_pkg::COUNT_W-1:0]       done;
  logic                              finished;

  logic                              pv;
  logic [wsh_pkg::SAMPLE_BITS-1:0]   p_val;
  logic                              p_clip, p_end;

  // combinational
  logic [wsh_pkg::FLOOR_W-1:0]       fl;
  logic [wsh_pkg::STEP_W-1:0]        step_eff;
  logic signed [wsh_pkg::DIFF_W-1:0] p, q;
  logic [wsh_pkg::MAG_W-1:0]         a, b;
  logic signed [wsh_pkg::MUL_W-1:0]  ma, mb;
  logic [wsh_pkg::BASIS_W-1:0]       u_b, v_b, f3_b;
  logic signed [wsh_pkg::PROD_W-1:0] rsum;
  logic [wsh_pkg::BASIS_W-1:0]       basis;
  logic signed [wsh_pkg::ACC_W-1:0]  prod_a, y0_a;
  logic signed [wsh_pkg::NUM_W-1:0]  num;
  logic [wsh_pkg::NUM_W-1:0]         mabs;
  logic [wsh_pkg::DEN_W:0]           dtrial;
  logic                              ge;
  logic [wsh_pkg::QUO_W-1:0]         qf;
  logic [wsh_pkg::QUO_W:0]           qr;
  logic [wsh_pkg::QUO_W-1:0]         sres;
  logic signed [wsh_pkg::ACC_W-1:0]  rs;
  logic signed [wsh_pkg::RQ_W-1:0]   rq;
  logic [wsh_pkg::SAMPLE_BITS-1:0]   sat_val;
  logic                              sat_clip;
  logic                              loop_go, tail_cond, oc, emit_ok;
  logic                              emit_go, flush_go, move, end_flag;
  logic [wsh_pkg::SAMPLE_BITS-1:0]   emit_val;
  logic                              emit_clip;

  function automatic logic signed [wsh_pkg::DIFF_W-1:0] diff(
    input logic [wsh_pkg::SAMPLE_BITS-1:0] hi,
    input logic [wsh_pkg::SAMPLE_BITS-1:0] lo
  );
    diff = $signed({hi[wsh_pkg::SAMPLE_BITS-1], hi})
         - $signed({lo[wsh_pkg::SAMPLE_BITS-1], lo});
  endfunction

  function automatic logic [wsh_pkg::MAG_W-1:0] floored_mag(
    input logic signed [wsh_pkg::DIFF_W-1:0] x,
    input logic [wsh_pkg::FLOOR_W-1:0]       f
  );
    logic [wsh_pkg::DIFF_W-1:0] m;
    logic [wsh_pkg::MAG_W-1:0]  s;
    m = x[wsh_pkg::DIFF_W-1] ? wsh_pkg::DIFF_W'(-x) : wsh_pkg::DIFF_W'(x);
    s = {m[wsh_pkg::DIFF_W-2:0], {wsh_pkg::SLOPE_FRAC{1'b0}}};
    floored_mag = (s < wsh_pkg::MAG_W'(f)) ? wsh_pkg::MAG_W'(f) : s;
  endfunction

  // config derived values
  assign fl       = (cfg.slope_floor == '0) ? wsh_pkg::FLOOR_W'(1) : cfg.slope_floor;
  assign step_eff = (cfg.phase_step < wsh_pkg::STEP_LEAST) ? wsh_pkg::STEP_LEAST
                                                            : cfg.phase_step;

  // slope operands
  assign p = pass ? dc : dd;
  assign q = pass ? du : dc;
  assign a = floored_mag(p, fl);
  assign b = floored_mag(q, fl);

  // basis operands
  assign u_b  = {{(wsh_pkg::BASIS_W-wsh_pkg::BASIS_BITS){1'b0}},
                 phase[wsh_pkg::PHASE_FRAC_BITS-1:0],
                 {(wsh_pkg::BASIS_BITS-wsh_pkg::PHASE_FRAC_BITS){1'b0}}};
  assign v_b  = wsh_pkg::BASIS_W'(1 << wsh_pkg::BASIS_BITS) - u_b;
  assign f3_b = wsh_pkg::BASIS_W'(3 << wsh_pkg::BASIS_BITS) - {u_b[wsh_pkg::BASIS_W-2:0], 1'b0};

  assign cidx = cnt - 1'b1;

  always_comb begin
    ma = '0;
    mb = '0;
    if (state == wsh_pkg::B_SLOPE) begin
      if (cnt == '0) begin
        ma = wsh_pkg::MUL_W'(p);
        mb = $signed({{(wsh_pkg::MUL_W-wsh_pkg::MAG_W){1'b0}}, b});
      end else begin
        ma = wsh_pkg::MUL_W'(q);
        mb = $signed({{(wsh_pkg::MUL_W-wsh_pkg::MAG_W){1'b0}}, a});
      end
    end else begin
      case (cnt)
        wsh_pkg::HS_UU: begin
          ma = $signed({{(wsh_pkg::MUL_W-wsh_pkg::BASIS_W){1'b0}}, u_b});
          mb = $signed({{(wsh_pkg::MUL_W-wsh_pkg::BASIS_W){1'b0}}, u_b});
        end
        wsh_pkg::HS_VV: begin
          ma = $signed({{(wsh_pkg::MUL_W-wsh_pkg::BASIS_W){1'b0}}, v_b});
          mb = $signed({{(wsh_pkg::MUL_W-wsh_pkg::BASIS_W){1'b0}}, v_b});
        end
        wsh_pkg::HS_H01: begin
          ma = $signed({{(wsh_pkg::MUL_W-wsh_pkg::BASIS_W){1'b0}}, uu});
          mb = $signed({{(wsh_pkg::MUL_W-wsh_pkg::BASIS_W){1'b0}}, f3_b});
        end
        wsh_pkg::HS_H10: begin
          ma = $signed({{(wsh_pkg::MUL_W-wsh_pkg::BASIS_W){1'b0}}, u_b});
          mb = $signed({{(wsh_pkg::MUL_W-wsh_pkg::BASIS_W){1'b0}}, vv});
        end
        wsh_pkg::HS_H11: begin
          ma = $signed({{(wsh_pkg::MUL_W-wsh_pkg::BASIS_W){1'b0}}, uu});
          mb = $signed({{(wsh_pkg::MUL_W-wsh_pkg::BASIS_W){1'b0}}, v_b});
        end
        wsh_pkg::HS_DY: begin
          ma = wsh_pkg::MUL_W'(dc);
          mb = $signed({{(wsh_pkg::MUL_W-wsh_pkg::BASIS_W){1'b0}}, h01});
        end
        wsh_pkg::HS_S0: begin
          ma = s0;
          mb = $signed({{(wsh_pkg::MUL_W-wsh_pkg::BASIS_W){1'b0}}, h10});
        end
        wsh_pkg::HS_S1: begin
          ma = s1;
          mb = $signed({{(wsh_pkg::MUL_W-wsh_pkg::BASIS_W){1'b0}}, h11});
        end
        default: begin
          ma = '0;
          mb = '0;
        end
      endcase
    end
  end

  // product rounding and accumulation terms
  assign rsum   = prod + wsh_pkg::PROD_W'(1 << (wsh_pkg::BASIS_BITS - 1));
  assign basis  = rsum[wsh_pkg::BASIS_BITS+wsh_pkg::BASIS_W-1:wsh_pkg::BASIS_BITS];
  assign prod_a = prod[wsh_pkg::ACC_W-1:0];
  assign y0_a   = $signed({{(wsh_pkg::ACC_W-wsh_pkg::SAMPLE_BITS){cmd.y0[wsh_pkg::SAMPLE_BITS-1]}},
                           cmd.y0});

  // slope numerator and division step
  assign num    = part + prod[wsh_pkg::NUM_W-1:0];
  assign mabs   = num[wsh_pkg::NUM_W-1] ? wsh_pkg::NUM_W'(-num) : wsh_pkg::NUM_W'(num);
  assign dtrial = {rem, dvd[wsh_pkg::QUO_W-1]};
  assign ge     = (dtrial >= {1'b0, den});
  assign qf     = {dvd[wsh_pkg::QUO_W-2:0], ge};
  assign qr     = {1'b0, qf} + 1'b1;
  assign sres   = neg ? (~qr[wsh_pkg::QUO_W:1] + 1'b1) : qr[wsh_pkg::QUO_W:1];

  // final rounding, halves up, then saturation
  assign rs = acc + wsh_pkg::ACC_W'(1 << (wsh_pkg::ACC_BITS - 1));
  assign rq = rs[wsh_pkg::ACC_W-1:wsh_pkg::ACC_BITS];

  always_comb begin
    sat_clip = 1'b0;
    sat_val  = rq[wsh_pkg::SAMPLE_BITS-1:0];
    if (rq > wsh_pkg::RQ_W'(wsh_pkg::SAMP_MAX)) begin
      sat_clip = 1'b1;
      sat_val  = wsh_pkg::SAMPLE_BITS'(wsh_pkg::SAMP_MAX);
    end else if (rq < wsh_pkg::RQ_W'(wsh_pkg::SAMP_MIN)) begin
      sat_clip = 1'b1;
      sat_val  = wsh_pkg::SAMPLE_BITS'(wsh_pkg::SAMP_MIN);
    end
  end

  assign loop_go   = !finished && (done < cfg.output_count) && (phase < wsh_pkg::PHASE_ONE);
  assign tail_cond = !finished && (done < cfg.output_count) && (phase == '0);
  assign oc        = !out_valid || out_ready;
  assign emit_ok   = !pv || oc;
  assign end_flag  = ({1'b0, done} + 1'b1) >= {1'b0, cfg.output_count};

  always_comb begin
    state_next = state;
    unique case (state)
      wsh_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          state_next = q_cmd.is_tail ? wsh_pkg::B_TAIL : wsh_pkg::B_SLOPE;
        end
      end
      wsh_pkg::B_SLOPE: begin
        if (cnt == wsh_pkg::SLOPE_LAST) begin
          state_next = wsh_pkg::B_DIV;
        end
      end
      wsh_pkg::B_DIV: begin
        if (cnt == wsh_pkg::DIV_LAST) begin
          state_next = pass ? wsh_pkg::B_LOOP : wsh_pkg::B_SLOPE;
        end
      end
      wsh_pkg::B_LOOP: begin
        if (loop_go) begin
          state_next = wsh_pkg::B_HERM;
        end else begin
          state_next = cmd.last ? wsh_pkg::B_FLUSH : wsh_pkg::B_IDLE;
        end
      end
      wsh_pkg::B_HERM: begin
        if (cnt == wsh_pkg::HERM_LAST) begin
          state_next = wsh_pkg::B_EMIT;
        end
      end
      wsh_pkg::B_EMIT: begin
        if (emit_ok) begin
          state_next = wsh_pkg::B_LOOP;
        end
      end
      wsh_pkg::B_TAIL: begin
        if (!tail_cond || emit_ok) begin
          state_next = wsh_pkg::B_FLUSH;
        end
      end
      wsh_pkg::B_FLUSH: begin
        if (!pv || oc) begin
          state_next = wsh_pkg::B_IDLE;
        end
      end
      default: state_next = wsh_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == wsh_pkg::B_IDLE) && !q_stat.empty;
    emit_go   = ((state == wsh_pkg::B_EMIT) && emit_ok)
             || ((state == wsh_pkg::B_TAIL) && tail_cond && emit_ok);
    flush_go  = (state == wsh_pkg::B_FLUSH) && pv && oc;
    move      = (emit_go && pv) || flush_go;
    emit_val  = (state == wsh_pkg::B_TAIL) ? cmd.y1 : sat_val;
    emit_clip = (state == wsh_pkg::B_TAIL) ? 1'b0 : sat_clip;
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
      dc  <= diff(q_cmd.y1, q_cmd.y0);
      dd  <= q_cmd.has_d ? diff(q_cmd.y0, q_cmd.yd) : diff(q_cmd.y1, q_cmd.y0);
      du  <= q_cmd.has_u ? diff(q_cmd.yu, q_cmd.y1) : diff(q_cmd.y1, q_cmd.y0);
    end
    if (state == wsh_pkg::B_SLOPE) begin
      if (cnt == wsh_pkg::CNT_W'(1)) begin
        part <= prod[wsh_pkg::NUM_W-1:0];
      end
      if (cnt == wsh_pkg::SLOPE_LAST) begin
        neg <= num[wsh_pkg::NUM_W-1];
        den <= wsh_pkg::DEN_W'(a) + wsh_pkg::DEN_W'(b);
        rem <= mabs[wsh_pkg::NUM_W-1:wsh_pkg::DROP];
        dvd <= {mabs[wsh_pkg::DROP-1:0], {(wsh_pkg::SLOPE_FRAC+1){1'b0}}};
      end
    end
    if (state == wsh_pkg::B_DIV) begin
      rem <= ge ? wsh_pkg::DEN_W'(dtrial - {1'b0, den}) : dtrial[wsh_pkg::DEN_W-1:0];
      dvd <= qf;
      if (cnt == wsh_pkg::DIV_LAST) begin
        if (pass) begin
          s1 <= $signed(sres[wsh_pkg::SLOPE_W-1:0]);
        end else begin
          s0 <= $signed(sres[wsh_pkg::SLOPE_W-1:0]);
        end
      end
    end
    if ((state == wsh_pkg::B_HERM) && (cnt != '0)) begin
      case (cidx)
        wsh_pkg::HS_UU:  uu  <= basis;
        wsh_pkg::HS_VV:  vv  <= basis;
        wsh_pkg::HS_H01: h01 <= basis;
        wsh_pkg::HS_H10: h10 <= basis;
        wsh_pkg::HS_H11: h11 <= basis;
        wsh_pkg::HS_DY:  acc <= (y0_a <<< wsh_pkg::ACC_BITS) + (prod_a <<< wsh_pkg::SLOPE_FRAC);
        wsh_pkg::HS_S0:  acc <= acc + prod_a;
        wsh_pkg::HS_S1:  acc <= acc - prod_a;
        default: ;
      endcase
    end
    if (emit_go) begin
      p_val  <= emit_val;
      p_clip <= emit_clip;
      p_end  <= end_flag;
    end
    if (move) begin
      out_sample <= p_val;
      out_clip   <= p_clip;
      out_end    <= p_end | (flush_go & cmd.fin);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wsh_pkg::B_IDLE;
      cnt       <= '0;
      pass      <= 1'b0;
      phase     <= '0;
      done      <= '0;
      finished  <= 1'b0;
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
      if (q_pop) begin
        pass <= 1'b0;
      end else if ((state == wsh_pkg::B_DIV) && (cnt == wsh_pkg::DIV_LAST)) begin
        pass <= 1'b1;
      end
      if ((state == wsh_pkg::B_LOOP) && !loop_go) begin
        if (done >= cfg.output_count) begin
          finished <= 1'b1;
        end
        phase <= (phase >= wsh_pkg::PHASE_ONE) ? phase - wsh_pkg::PHASE_ONE : '0;
      end
      if ((state == wsh_pkg::B_EMIT) && emit_ok) begin
        phase <= phase + wsh_pkg::PHASE_W'(step_eff);
      end
      if (emit_go) begin
        done <= done + 1'b1;
        if (end_flag) begin
          finished <= 1'b1;
        end
      end
      if ((state == wsh_pkg::B_FLUSH) && (!pv || oc) && cmd.fin) begin
        phase    <= '0;
        done     <= '0;
        finished <= 1'b0;
      end
      if (emit_go) begin
        pv <= 1'b1;
      end else if (flush_go) begin
        pv <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/weighted_slope_hermite_resampler.sv
// each word that closes an interval starts two slope setups and 36-step divisions, then
//   one hermite value per output time, on the shared divider and multiplier
// a word that closes no interval is only split up; a new word is taken once the previous
//   one has been split into commands, and the front waits while the command queue is full
// reset: rst is synchronous and active high; it clears the record state, the queue
//   and the output stage and loads the register defaults
module weighted_slope_hermite_resampler (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [23:0]                       s_tdata,   // sample_in
  input  logic                              s_tlast,   // final_sample
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [23:0]                       m_tdata,   // sample_out
  output logic                              m_tuser,   // clipped
  output logic                              m_tlast,   // run_end
  // register writes
  input  logic                              cfg_we,
  input  logic [wsh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wsh_pkg::CFG_W-1:0]         cfg_data
);

  wsh_pkg::cfg_t    cfg;
  wsh_pkg::cmd_t    push_cmd;
  wsh_pkg::cmd_t    head_cmd;
  wsh_pkg::q_stat_t q_stat;
  logic             q_push;
  logic             q_pop;

  // register file: phase step, slope floor, output count
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step   <= wsh_pkg::RST_PHASE_STEP;
      cfg.slope_floor  <= wsh_pkg::RST_SLOPE_FLOOR;
      cfg.output_count <= wsh_pkg::RST_OUTPUT_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        wsh_pkg::CFG_PHASE_STEP:   cfg.phase_step   <= cfg_data[wsh_pkg::STEP_W-1:0];
        wsh_pkg::CFG_SLOPE_FLOOR:  cfg.slope_floor  <= cfg_data[wsh_pkg::FLOOR_W-1:0];
        wsh_pkg::CFG_OUTPUT_COUNT: cfg.output_count <= cfg_data[wsh_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: sample window and splitting of each word into interval commands
  wsh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_sample (s_tdata),
    .in_final  (s_tlast),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // short command queue decoupling the two sides
  wsh_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .cmd_in  (push_cmd),
    .pop     (q_pop),
    .cmd_out (head_cmd),
    .stat    (q_stat)
  );

  // back end: slopes, hermite values, output phase and count, output register
  wsh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_stat     (q_stat),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_sample (m_tdata),
    .out_clip   (m_tuser),
    .out_end    (m_tlast)
  );

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("command queue overflow");

  // the back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("command queue underflow");

  // a new word is taken only once the previous one has been split up
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while commands still pending");

endmodule

>>> tb/sv/weighted_slope_hermite_resampler_tb.sv
module weighted_slope_hermite_resampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsh_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int SETTLE       = 1000;  // quiet cycles before a register write / at the end

  typedef enum logic [1:0] {
    K_WORD,
    K_PAUSE,
    K_REG,
    K_IDLING
  } stim_kind_t;

  typedef struct {
    stim_kind_t             kind;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   fin;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_W-1:0]       value;
    int                     snd_idle;
    int                     rcv_idle;
  } stim_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   clip;
    logic                   last;
  } out_word_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [23:0]            s_tdata;   // sample_in
  logic                   s_tlast;   // final_sample
  logic                   m_tvalid;
  logic                   m_tready;
  logic [23:0]            m_tdata;   // sample_out
  logic                   m_tuser;   // clipped
  logic                   m_tlast;   // run_end
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  weighted_slope_hermite_resampler u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // stimulus still to send and resampled words still to arrive
  stim_t     stim_q[$];
  out_word_t resampled_q[$];

  // shadow registers
  int unsigned step_reg;
  int unsigned floor_reg;
  int unsigned count_reg;

  // shadow record state
  longint      win[3];
  int unsigned seen;
  int unsigned phase;
  int unsigned done_cnt;
  bit          count_hit;
  int          words_this_step;

  int  errors;
  int  cycles;
  int  quiet;
  int  words_in;
  int  words_out;
  int  clips_seen;
  int  records_ended;
  int  snd_idle;
  int  rcv_idle;
  bit  sent;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // inverse-magnitude weighted slope of differences p and q, Q8
  function automatic longint weighted_slope(longint p, longint q);
    longint unsigned fl, a, b, num, m, den, qt, r, res;
    bit neg;
    fl  = (floor_reg == 0) ? 64'd1 : 64'(floor_reg);
    a   = $unsigned(p < 0 ? -p : p) << SLOPE_FRAC;
    b   = $unsigned(q < 0 ? -q : q) << SLOPE_FRAC;
    if (a < fl) a = fl;
    if (b < fl) b = fl;
    num = $unsigned(p) * b + $unsigned(q) * a;
    neg = num[63];
    m   = neg ? -num : num;
    den = a + b;
    qt  = m / den;
    r   = m % den;
    res = (qt << SLOPE_FRAC) + ((r << (SLOPE_FRAC + 1)) + den) / (2 * den);
    return neg ? $signed(-res) : $signed(res);
  endfunction

  function automatic longint unsigned round_basis(longint unsigned x);
    return (x + (64'd1 << (BASIS_BITS - 1))) >> BASIS_BITS;
  endfunction

  // cubic hermite value at phase ph between y0 and y1
  function automatic longint hermite_value(longint y0, longint y1, longint s0, longint s1,
                                           int unsigned ph);
    longint unsigned one, u, v, uu, vv, h01, h10, h11, acc, m;
    longint s;
    if (ph == 0) return y0;
    one = 64'd1 << BASIS_BITS;
    u   = 64'(ph) << (BASIS_BITS - PHASE_FRAC_BITS);
    v   = one - u;
    uu  = round_basis(u * u);
    vv  = round_basis(v * v);
    h01 = round_basis(uu * (3 * one - 2 * u));
    h10 = round_basis(u * vv);
    h11 = round_basis(uu * v);
    acc = ($unsigned(y0) << ACC_BITS)
        + (($unsigned(y1 - y0) * h01) << SLOPE_FRAC)
        + $unsigned(s0) * h10 - $unsigned(s1) * h11;
    s = $signed(acc + (64'd1 << (ACC_BITS - 1)));
    if (s >= 0) return s >>> ACC_BITS;
    m = -$unsigned(s);
    return -$signed((m + (64'd1 << ACC_BITS) - 1) >> ACC_BITS);
  endfunction

  function automatic void push_resampled(longint val);
    out_word_t w;
    w.clip = 1'b0;
    w.last = 1'b0;
    if (val > SAMP_MAX) begin
      val    = SAMP_MAX;
      w.clip = 1'b1;
    end
    if (val < SAMP_MIN) begin
      val    = SAMP_MIN;
      w.clip = 1'b1;
    end
    done_cnt++;
    if (done_cnt >= count_reg) begin
      count_hit = 1'b1;
      w.last    = 1'b1;
    end
    w.sample = val[SAMPLE_BITS-1:0];
    resampled_q.push_back(w);
    words_this_step++;
  endfunction

  // all outputs that fall in the interval y0..y1
  function automatic void resolve_interval(longint yd, longint y0, longint y1, longint yu,
                                           bit has_d, bit has_u);
    int unsigned step;
    longint dc, dd, du, s0, s1;
    step = (step_reg < STEP_LEAST) ? STEP_LEAST : step_reg;
    dc   = y1 - y0;
    dd   = has_d ? y0 - yd : dc;
    du   = has_u ? yu - y1 : dc;
    s0   = weighted_slope(dd, dc);
    s1   = weighted_slope(dc, du);
    while (!count_hit && done_cnt < count_reg && phase < PHASE_ONE) begin
      push_resampled(hermite_value(y0, y1, s0, s1, phase));
      phase += step;
    end
    if (done_cnt >= count_reg) count_hit = 1'b1;
    if (phase >= PHASE_ONE) phase -= PHASE_ONE;
    else phase = 0;
  endfunction

  function automatic void clear_record();
    win       = '{0, 0, 0};
    seen      = 0;
    phase     = 0;
    done_cnt  = 0;
    count_hit = 1'b0;
  endfunction

  // one accepted input word
  function automatic void resample_word(logic [SAMPLE_BITS-1:0] sample, logic fin);
    longint s;
    s = $signed(sample);
    words_this_step = 0;
    if (seen < SEEN_MAX) seen++;
    if (seen >= 3) resolve_interval(win[0], win[1], win[2], s, seen >= 4, 1'b1);
    if (fin) begin
      if (seen >= 2) resolve_interval(win[1], win[2], s, 0, seen >= 3, 1'b0);
      // an output time landing on the last sample yields it unchanged
      if (!count_hit && done_cnt < count_reg && phase == 0) push_resampled(s);
      if (words_this_step > 0) resampled_q[resampled_q.size()-1].last = 1'b1;
      clear_record();
      records_ended++;
    end else begin
      win[0] = win[1];
      win[1] = win[2];
      win[2] = s;
    end
  endfunction

  function automatic void write_shadow(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    case (idx)
      CFG_PHASE_STEP:   step_reg  = value[STEP_W-1:0];
      CFG_SLOPE_FLOOR:  floor_reg = value[FLOOR_W-1:0];
      CFG_OUTPUT_COUNT: count_reg = value[COUNT_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus queue fillers
  // ---------------------------------------------------------------------------

  function automatic void add_word(logic [SAMPLE_BITS-1:0] sample, logic fin);
    stim_t t;
    t        = '{kind: K_WORD, default: '0};
    t.kind   = K_WORD;
    t.sample = sample;
    t.fin    = fin;
    stim_q.push_back(t);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    stim_t t;
    t       = '{kind: K_REG, default: '0};
    t.kind  = K_REG;
    t.idx   = idx;
    t.value = value;
    stim_q.push_back(t);
  endfunction

  function automatic void add_pause();
    stim_t t;
    t      = '{kind: K_PAUSE, default: '0};
    t.kind = K_PAUSE;
    stim_q.push_back(t);
  endfunction

  function automatic void add_idling(int snd, int rcv);
    stim_t t;
    t          = '{kind: K_IDLING, default: '0};
    t.kind     = K_IDLING;
    t.snd_idle = snd;
    t.rcv_idle = rcv;
    stim_q.push_back(t);
  endfunction

  // one record: 0 random full range, 1 slow walk, 2 alternating extremes;
  // with open set the last word carries no end mark
  function automatic int add_record(int len, int style, bit open);
    int v;
    v = $signed(24'($urandom));
    for (int i = 0; i < len; i++) begin
      case (style)
        0: v = $signed(24'($urandom));
        1: v = v + $signed(12'($urandom));
        default: v = (i % 2) ? SAMP_MIN : SAMP_MAX;
      endcase
      add_word(24'(v), (i == len - 1) && !open);
    end
    return len;
  endfunction

  // ---------------------------------------------------------------------------
  // clock, reset, timeout
  // ---------------------------------------------------------------------------

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (resampled_q.size() != 0 || s_tvalid) quiet = 0;
    else quiet++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words still awaited", cycles, resampled_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: input words, register writes, pauses
  // ---------------------------------------------------------------------------

  // a word is taken at the rising edge; the predictor runs on it there
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      resample_word(s_tdata, s_tlast);
      words_in++;
      sent = 1'b1;
    end
  end

  always @(negedge clk) begin : drive
    logic                   nv, we, busy;
    logic [SAMPLE_BITS-1:0] nd;
    logic                   nl;
    logic [CFG_IDX_W-1:0]   ni;
    logic [CFG_W-1:0]       nc;
    stim_t                  t;
    nv   = s_tvalid && !sent;
    nd   = s_tdata;
    nl   = s_tlast;
    we   = 1'b0;
    ni   = cfg_index;
    nc   = cfg_data;
    busy = rst || nv;
    sent = 1'b0;
    while (!busy && stim_q.size() != 0) begin
      t = stim_q[0];
      case (t.kind)
        K_IDLING: begin
          snd_idle = t.snd_idle;
          rcv_idle = t.rcv_idle;
          void'(stim_q.pop_front());
        end
        K_PAUSE: begin
          // hold off until every awaited word has come back
          if (resampled_q.size() == 0) void'(stim_q.pop_front());
          else busy = 1'b1;
        end
        K_REG: begin
          // only write once the block has had time to go idle
          if (resampled_q.size() == 0 && quiet >= SETTLE) begin
            we = 1'b1;
            ni = t.idx;
            nc = t.value;
            write_shadow(t.idx, t.value);
            void'(stim_q.pop_front());
          end
          busy = 1'b1;
        end
        default: begin
          if ($urandom_range(99) >= snd_idle) begin
            nv = 1'b1;
            nd = t.sample;
            nl = t.fin;
            void'(stim_q.pop_front());
          end
          busy = 1'b1;
        end
      endcase
    end
    s_tvalid  <= nv;
    s_tdata   <= nd;
    s_tlast   <= nl;
    cfg_we    <= we;
    cfg_index <= ni;
    cfg_data  <= nc;
    m_tready  <= ($urandom_range(99) >= rcv_idle);
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each output word with the oldest prediction
  // ---------------------------------------------------------------------------

  task automatic report(string what, longint exp_v, longint got_v);
    errors++;
    $display("mismatch at cycle %0d, word %0d: %s expected %0d got %0d",
             cycles, words_out, what, exp_v, got_v);
  endtask

  always @(posedge clk) begin : monitor
    out_word_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (resampled_q.size() == 0) begin
        report("unexpected word, sample_out", 0, $signed(m_tdata));
      end else begin
        w = resampled_q.pop_front();
        if (m_tdata !== w.sample) report("sample_out", $signed(w.sample), $signed(m_tdata));
        if (m_tuser !== w.clip)   report("clipped", w.clip, m_tuser);
        if (m_tlast !== w.last)   report("run_end", w.last, m_tlast);
        if (w.clip) clips_seen++;
      end
      words_out++;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus plan and end of run
  // ---------------------------------------------------------------------------

  initial begin : plan
    int n;
    int len;
    int style;
    clk       = 1'b0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_PHASE_STEP;
    cfg_data  = '0;
    snd_idle  = 0;
    rcv_idle  = 0;
    step_reg  = RST_PHASE_STEP;
    floor_reg = RST_SLOPE_FLOOR;
    count_reg = RST_OUTPUT_COUNT;
    clear_record();

    // directed: register defaults first
    add_idling(0, 0);
    add_word(24'h7FFFFF, 1'b1);                 // one-sample record
    add_word(24'h800000, 1'b0);                 // two-sample record across the full range
    add_word(24'h7FFFFF, 1'b1);
    // finest step with swings that overshoot and clip
    add_reg(CFG_PHASE_STEP, 24'd4096);
    void'(add_record(4, 2, 1'b0));
    // step below the least allowed, widest floor
    add_reg(CFG_PHASE_STEP, 24'd100);
    add_reg(CFG_SLOPE_FLOOR, 24'hFFFFFF);
    void'(add_record(3, 1, 1'b0));
    // zero floor, largest steps
    add_reg(CFG_SLOPE_FLOOR, 24'd0);
    add_reg(CFG_PHASE_STEP, 24'h7FFFFF);
    void'(add_record(3, 0, 1'b0));
    add_reg(CFG_PHASE_STEP, 24'd4194304);
    void'(add_record(3, 0, 1'b0));
    // count reached inside a record
    add_reg(CFG_PHASE_STEP, 24'd30000);
    add_reg(CFG_OUTPUT_COUNT, 24'd3);
    void'(add_record(4, 1, 1'b0));
    // count lowered below what the record has already made
    add_reg(CFG_PHASE_STEP, 24'd4096);
    add_reg(CFG_OUTPUT_COUNT, 24'd1024);
    void'(add_record(3, 0, 1'b1));
    add_pause();
    add_reg(CFG_OUTPUT_COUNT, 24'd2);
    void'(add_record(2, 0, 1'b0));
    // zero count: nothing at all
    add_reg(CFG_OUTPUT_COUNT, 24'd0);
    void'(add_record(2, 0, 1'b0));

    // random phases, each with its own idling pattern and registers
    for (int ph = 0; ph < 3; ph++) begin
      add_idling(ph == 0 ? 19 : (ph == 1 ? 87 : 0), ph == 0 ? 87 : (ph == 1 ? 19 : 0));
      add_reg(CFG_PHASE_STEP, ($urandom_range(9) < 7) ? $urandom_range(4096, 200000)
                                                       : $urandom_range(0, 8388607));
      add_reg(CFG_SLOPE_FLOOR, $urandom_range(1) ? $urandom_range(0, 4096)
                                                 : $urandom_range(0, 16777215));
      add_reg(CFG_OUTPUT_COUNT, ($urandom_range(4) == 0) ? $urandom_range(0, 20)
                                                          : 24'hFFFFFF);
      n = 0;
      while (n < 31) begin
        len   = $urandom_range(1, 8);
        style = ($urandom_range(9) < 6) ? 0 : ($urandom_range(9) < 8 ? 1 : 2);
        // now and then a record that runs on into the next one
        n += add_record(len, style, $urandom_range(9) == 0);
      end
      add_word(24'($urandom), 1'b1);
      add_pause();
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (stim_q.size() != 0 || resampled_q.size() != 0 || s_tvalid) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("sent %0d sample words over %0d records, checked %0d resampled words",
             words_in, records_ended, words_out);
    $display("%0d clipped words seen, %0d mismatches", clips_seen, errors);
    if (errors == 0 && resampled_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
